// ===== design/ray_triangle_intersection_unit_macros.svh =====
// Assertion macros used by the checker of the ray/triangle unit.
`ifndef RAY_TRIANGLE_INTERSECTION_UNIT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rti_pkg.sv =====
// Types and constants of the ray/triangle intersection unit.
package rti_pkg;

	localparam int COORD_W    = 32;   // Q16.16 coordinate
	localparam int DIFF_W     = 33;   // difference of two coordinates
	localparam int PROD_W     = 66;   // product of two differences
	localparam int CROSS_W    = 67;   // cross product component
	localparam int LO_W       = 34;   // low slice of a cross component
	localparam int PLO_W      = 68;   // low slice times a difference
	localparam int WIDE_W     = 104;  // triple products and their sums
	localparam int REM_W      = 132;  // division remainder
	localparam int FRAC_W     = 16;   // fraction bits of Q16.16
	localparam int DIST_W     = 31;
	localparam int DIV_STEPS  = 31;
	localparam int THR_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;

	typedef enum logic [2:0] {
		OC_HIT        = 3'd0,
		OC_DEGENERATE = 3'd1,
		OC_PARALLEL   = 3'd2,
		OC_BEHIND     = 3'd3,
		OC_OUTSIDE    = 3'd4
	} outcome_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [PLO_W-1:0]   plo_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;

endpackage

// ===== design/ray_triangle_intersection_unit.sv =====
// Throughput: one triangle per cycle unless the output stalls; 8 arithmetic
// stages (cross products, split triple products, sums, classify) feed a
// 32-stage restoring divider.
// The whole pipe holds while the output register is full and stalled.
// Reset clears all valid bits and loads the ray registers with their
// defaults: origin 0, direction +x, parallel threshold 1.
module ray_triangle_intersection_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rti_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex0_x,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex0_y,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex0_z,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex1_x,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex1_y,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex1_z,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex2_x,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex2_y,
	input  logic signed [rti_pkg::COORD_W-1:0] vertex2_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [rti_pkg::DIST_W-1:0]        distance,
	output logic [2:0]                        outcome
);
	import rti_pkg::*;

	// configuration registers
	coord_t            org_q [3];
	coord_t            dir_q [3];
	logic [THR_W-1:0]  thr_q;

	// pipeline advance
	logic adv;

	// stage 1: edge vectors
	logic  vld_s1;
	diff_t u_s1 [3];
	diff_t v_s1 [3];
	diff_t w_s1 [3];
	diff_t u_c [3];
	diff_t v_c [3];
	diff_t w_c [3];
	coord_t vx0 [3];
	coord_t vx1 [3];
	coord_t vx2 [3];

	// stage 2: cross product terms
	logic  vld_s2;
	prod_t pm_s2 [3][3][2];
	prod_t pm_c  [3][3][2];
	diff_t w_s2 [3];

	// stage 3: cross products
	logic   vld_s3;
	cross_t cr_s3 [3][3];
	cross_t cr_c  [3][3];
	logic   deg_s3;
	logic   deg_c;
	diff_t  w_s3 [3];

	// stage 4: split triple product terms
	logic  vld_s4;
	plo_t  pl_s4 [4][3];
	prod_t ph_s4 [4][3];
	plo_t  pl_c  [4][3];
	prod_t ph_c  [4][3];
	logic  deg_s4;

	// stage 5: joined terms
	logic  vld_s5;
	wide_t pr_s5 [4][3];
	wide_t pr_c  [4][3];
	logic  deg_s5;

	// stage 6: sums a, b, s, t
	logic  vld_s6;
	wide_t dt_s6 [4];
	wide_t dt_c  [4];
	logic  deg_s6;

	// stage 7: sign normalized
	logic  vld_s7;
	wide_t a_s7, b_s7, s_s7, t_s7;
	logic  deg_s7;

	// stage 8: classified
	logic              vld_s8;
	logic [WIDE_W-1:0] a_s8, b_s8;
	outcome_t          code_s8;
	outcome_t          code_c;
	wide_t             st_sum;

	// divider stages
	logic              div_vld_s  [DIV_STEPS+1];
	logic [REM_W-1:0]  div_rem_s  [DIV_STEPS+1];
	logic [WIDE_W-1:0] div_b_s    [DIV_STEPS+1];
	logic [DIST_W-1:0] div_q_s    [DIV_STEPS+1];
	logic              div_sat_s  [DIV_STEPS+1];
	outcome_t          div_code_s [DIV_STEPS+1];
	logic [REM_W-1:0]  rem_n [DIV_STEPS+1];
	logic [DIST_W-1:0] q_n   [DIV_STEPS+1];
	logic [REM_W-1:0]  rem0_c;
	logic              sat0_c;

	// output register
	logic              out_valid_q;
	logic              hit_q;
	logic [DIST_W-1:0] dist_q;
	outcome_t          oc_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= COORD_W'(65536);
			dir_q[1] <= '0;
			dir_q[2] <= '0;
			thr_q    <= THR_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:  org_q[0] <= cfg_data;
				CFG_ORIGIN_Y:  org_q[1] <= cfg_data;
				CFG_ORIGIN_Z:  org_q[2] <= cfg_data;
				CFG_DIR_X:     dir_q[0] <= cfg_data;
				CFG_DIR_Y:     dir_q[1] <= cfg_data;
				CFG_DIR_Z:     dir_q[2] <= cfg_data;
				CFG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign vx0[0] = vertex0_x;
	assign vx0[1] = vertex0_y;
	assign vx0[2] = vertex0_z;
	assign vx1[0] = vertex1_x;
	assign vx1[1] = vertex1_y;
	assign vx1[2] = vertex1_z;
	assign vx2[0] = vertex2_x;
	assign vx2[1] = vertex2_y;
	assign vx2[2] = vertex2_z;

	// edge vectors and origin offset
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_c[i] = DIFF_W'(vx1[i]) - DIFF_W'(vx0[i]);
			v_c[i] = DIFF_W'(vx2[i]) - DIFF_W'(vx0[i]);
			w_c[i] = DIFF_W'(org_q[i]) - DIFF_W'(vx0[i]);
		end
	end

	// cross product terms for n = u x v, c1 = w0 x v, c2 = u x w0
	always_comb begin
		int j1;
		int j2;
		for (int j = 0; j < 3; j++) begin
			j1 = (j == 2) ? 0 : j + 1;
			j2 = (j == 0) ? 2 : j - 1;
			pm_c[0][j][0] = u_s1[j1] * v_s1[j2];
			pm_c[0][j][1] = u_s1[j2] * v_s1[j1];
			pm_c[1][j][0] = w_s1[j1] * v_s1[j2];
			pm_c[1][j][1] = w_s1[j2] * v_s1[j1];
			pm_c[2][j][0] = u_s1[j1] * w_s1[j2];
			pm_c[2][j][1] = u_s1[j2] * w_s1[j1];
		end
	end

	// cross products and degenerate test
	always_comb begin
		for (int p = 0; p < 3; p++) begin
			for (int j = 0; j < 3; j++) begin
				cr_c[p][j] = CROSS_W'(pm_s2[p][j][0]) - CROSS_W'(pm_s2[p][j][1]);
			end
		end
		deg_c = (cr_c[0][0] == '0) && (cr_c[0][1] == '0) && (cr_c[0][2] == '0);
	end

	// triple product terms, each cross component split into two slices
	always_comb begin
		cross_t x;
		diff_t  y;
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				x = (k == 0 || k == 1) ? cr_s3[0][i] : cr_s3[k-1][i];
				y = (k == 0) ? w_s3[i] : DIFF_W'(dir_q[i]);
				pl_c[k][i] = $signed({1'b0, x[LO_W-1:0]}) * y;
				ph_c[k][i] = $signed(x[CROSS_W-1:LO_W]) * y;
			end
		end
	end

	// join slices
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				pr_c[k][i] = (WIDE_W'(ph_s4[k][i]) <<< LO_W) + WIDE_W'(pl_s4[k][i]);
			end
		end
	end

	// sum terms; a is the negated plane offset
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dt_c[k] = pr_s5[k][0] + pr_s5[k][1] + pr_s5[k][2];
		end
		dt_c[0] = -dt_c[0];
	end

	// classify the hit
	always_comb begin
		st_sum = s_s7 + t_s7;
		if (deg_s7) begin
			code_c = OC_DEGENERATE;
		end else if (b_s7 == '0 || b_s7 < $signed(WIDE_W'(thr_q))) begin
			code_c = OC_PARALLEL;
		end else if (a_s7[WIDE_W-1]) begin
			code_c = OC_BEHIND;
		end else if (s_s7[WIDE_W-1] || s_s7 > b_s7 || t_s7[WIDE_W-1] || st_sum > b_s7) begin
			code_c = OC_OUTSIDE;
		end else begin
			code_c = OC_HIT;
		end
	end

	// divider: saturation check, then one quotient bit per stage
	always_comb begin
		rem0_c = REM_W'(a_s8) << FRAC_W;
		sat0_c = rem0_c >= (REM_W'(b_s8) << DIV_STEPS);
		rem_n[0] = rem0_c;
		q_n[0]   = '0;
		for (int k = 1; k <= DIV_STEPS; k++) begin
			rem_n[k] = div_rem_s[k-1];
			q_n[k]   = div_q_s[k-1];
			if (div_rem_s[k-1] >= (REM_W'(div_b_s[k-1]) << (DIV_STEPS - k))) begin
				rem_n[k] = div_rem_s[k-1] - (REM_W'(div_b_s[k-1]) << (DIV_STEPS - k));
				q_n[k][DIV_STEPS-k] = 1'b1;
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				div_vld_s[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			div_vld_s[0] <= vld_s8;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_vld_s[k] <= div_vld_s[k-1];
			end
			out_valid_q <= div_vld_s[DIV_STEPS];
		end
	end

	// advance data
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= u_c;
			v_s1 <= v_c;
			w_s1 <= w_c;
			pm_s2 <= pm_c;
			w_s2  <= w_s1;
			cr_s3  <= cr_c;
			deg_s3 <= deg_c;
			w_s3   <= w_s2;
			pl_s4  <= pl_c;
			ph_s4  <= ph_c;
			deg_s4 <= deg_s3;
			pr_s5  <= pr_c;
			deg_s5 <= deg_s4;
			dt_s6  <= dt_c;
			deg_s6 <= deg_s5;
			deg_s7 <= deg_s6;
			if (dt_s6[1][WIDE_W-1]) begin
				a_s7 <= -dt_s6[0];
				b_s7 <= -dt_s6[1];
				s_s7 <= -dt_s6[2];
				t_s7 <= -dt_s6[3];
			end else begin
				a_s7 <= dt_s6[0];
				b_s7 <= dt_s6[1];
				s_s7 <= dt_s6[2];
				t_s7 <= dt_s6[3];
			end
			a_s8    <= a_s7;
			b_s8    <= b_s7;
			code_s8 <= code_c;
			div_rem_s[0]  <= rem_n[0];
			div_q_s[0]    <= q_n[0];
			div_b_s[0]    <= b_s8;
			div_sat_s[0]  <= sat0_c;
			div_code_s[0] <= code_s8;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_rem_s[k]  <= rem_n[k];
				div_q_s[k]    <= q_n[k];
				div_b_s[k]    <= div_b_s[k-1];
				div_sat_s[k]  <= div_sat_s[k-1];
				div_code_s[k] <= div_code_s[k-1];
			end
			hit_q <= (div_code_s[DIV_STEPS] == OC_HIT);
			oc_q  <= div_code_s[DIV_STEPS];
			if (div_code_s[DIV_STEPS] != OC_HIT) begin
				dist_q <= '0;
			end else if (div_sat_s[DIV_STEPS]) begin
				dist_q <= '1;
			end else begin
				dist_q <= div_q_s[DIV_STEPS];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign distance  = dist_q;
	assign outcome   = oc_q;

endmodule

// ===== design/rti_checker.sv =====
// Port checker for the ray/triangle unit and its bind.
`include "ray_triangle_intersection_unit_macros.svh"

module rti_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       hit,
	input logic [rti_pkg::DIST_W-1:0] distance,
	input logic [2:0]                 outcome
);
	import rti_pkg::*;

	// hold a stalled result word
	`RTI_ASSERT_NXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid, "stalled word dropped")
	`RTI_ASSERT_NXT(a_hold_data, clk, arst_n, out_valid && out_stall, $stable(hit) && $stable(distance) && $stable(outcome), "stalled word changed")
	// hit flag agrees with outcome; misses report zero distance
	`RTI_ASSERT_IMP(a_hit_code, clk, arst_n, out_valid, hit == (outcome == OC_HIT), "hit and outcome disagree")
	`RTI_ASSERT_IMP(a_miss_dist, clk, arst_n, out_valid && !hit, distance == '0, "miss with nonzero distance")

endmodule

bind ray_triangle_intersection_unit rti_checker u_rti_checker (.*);
